FILE: rtl/sfade_pkg.sv
// ----------------------------------------------------------------------------
// sfade_pkg - shared types and constants for the segment fade block
// Field widths, stage payload structs and the restoring divide step.
// ----------------------------------------------------------------------------
`default_nettype none

package sfade_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DUR_W     = 20;
    localparam int unsigned LEN_W     = 31;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned ALPHA_W   = FRAC_W + 1;
    // wide enough for t - (len - fade_out) without overflow
    localparam int unsigned DIFF_W    = TIME_W + 2;

    localparam int unsigned DIV_STAGES      = 8;
    localparam int unsigned STEPS_PER_STAGE = FRAC_W / DIV_STAGES;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << FRAC_W;
    localparam logic signed [SAMPLE_W:0] CHROMA_MID = (SAMPLE_W + 1)'(128);

    localparam logic [OP_W-1:0] OP_CHROMA = 2'd1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = LEN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       in_act;
        logic                       in_zero;
        logic [DUR_W-1:0]           num_in;
        logic                       out_act;
        logic                       out_zero;
        logic [DUR_W-1:0]           num_out;
    } t_prep;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       in_act;
        logic                       in_zero;
        logic [DUR_W-1:0]           rem_in;
        logic [FRAC_W-1:0]          q_in;
        logic                       out_act;
        logic                       out_zero;
        logic [DUR_W-1:0]           rem_out;
        logic [FRAC_W-1:0]          q_out;
    } t_div;

    typedef struct packed {
        logic [ALPHA_W-1:0]         alpha;
        logic signed [SAMPLE_W-1:0] sample_out;
    } t_res;

    // One restoring step: rem < den on entry and on exit. Returns {qbit, rem}.
    function automatic logic [DUR_W:0] div_step(input logic [DUR_W-1:0] rem,
                                                input logic [DUR_W-1:0] den);
        logic [DUR_W:0] dbl;
        logic [DUR_W:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, den};
        if (dbl >= {1'b0, den}) begin
            return {1'b1, diff[DUR_W-1:0]};
        end else begin
            return {1'b0, dbl[DUR_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sfade_prep.sv
// ----------------------------------------------------------------------------
// sfade_prep - window decode stage
// Decides which fade windows hold the item and forms the divide numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module sfade_prep (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic [sfade_pkg::DUR_W-1:0]             i_fade_in,
    input  wire logic [sfade_pkg::DUR_W-1:0]             i_fade_out,
    input  wire logic [sfade_pkg::LEN_W-1:0]             i_seg_len,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [sfade_pkg::OP_W-1:0]              i_op,
    input  wire logic signed [sfade_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic signed [sfade_pkg::TIME_W-1:0]     i_time,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output sfade_pkg::t_prep                             o_data
);

    localparam int unsigned DW = sfade_pkg::DIFF_W;

    logic                       r_vld;
    sfade_pkg::t_prep           r_data;
    sfade_pkg::t_prep           n_data;
    logic                       en;
    logic signed [DW-1:0]       t_ext;
    logic signed [DW-1:0]       fi_ext;
    logic signed [DW-1:0]       fo_ext;
    logic signed [DW-1:0]       len_ext;
    logic signed [DW-1:0]       diff;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        t_ext   = DW'(i_time);
        fi_ext  = $signed({{(DW - sfade_pkg::DUR_W){1'b0}}, i_fade_in});
        fo_ext  = $signed({{(DW - sfade_pkg::DUR_W){1'b0}}, i_fade_out});
        len_ext = $signed({{(DW - sfade_pkg::LEN_W){1'b0}}, i_seg_len});
        // distance past the fade-out start
        diff    = t_ext - len_ext + fo_ext;

        n_data.op       = i_op;
        n_data.sample   = i_sample;
        n_data.in_act   = (i_fade_in != '0) && (t_ext < fi_ext);
        // at or before zero time the fade-in gain truncates to zero
        n_data.in_zero  = i_time[sfade_pkg::TIME_W-1] || (i_time == '0);
        n_data.num_in   = i_time[sfade_pkg::DUR_W-1:0];
        n_data.out_act  = (i_fade_out != '0) && !diff[DW-1];
        n_data.out_zero = diff >= fo_ext;
        n_data.num_out  = diff[sfade_pkg::DUR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfade_div.sv
// ----------------------------------------------------------------------------
// sfade_div - pipelined fractional divider, two lanes
// Forms floor(num * 2^16 / den) for the fade-in and fade-out lanes,
// a fixed number of restoring steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfade_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [sfade_pkg::DUR_W-1:0]  i_fade_in,
    input  wire logic [sfade_pkg::DUR_W-1:0]  i_fade_out,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire sfade_pkg::t_prep             i_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output sfade_pkg::t_div                   o_data
);

    localparam int unsigned NS = sfade_pkg::DIV_STAGES;
    localparam int unsigned SP = sfade_pkg::STEPS_PER_STAGE;
    localparam int unsigned DW = sfade_pkg::DUR_W;
    localparam int unsigned QW = sfade_pkg::FRAC_W;

    logic             r_vld [NS];
    sfade_pkg::t_div  r_st  [NS];
    logic             en    [NS+1];
    sfade_pkg::t_div  head;

    always_comb begin
        head         = '0;
        head.op      = i_data.op;
        head.sample  = i_data.sample;
        head.in_act  = i_data.in_act;
        head.in_zero = i_data.in_zero;
        head.rem_in  = i_data.num_in;
        head.out_act = i_data.out_act;
        head.out_zero = i_data.out_zero;
        head.rem_out = i_data.num_out;
    end

    assign en[NS]  = i_ready;
    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_data  = r_st[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        sfade_pkg::t_div src;
        sfade_pkg::t_div n_st;
        logic            src_vld;

        if (k == 0) begin : g_head
            assign src     = head;
            assign src_vld = i_valid;
        end else begin : g_link
            assign src     = r_st[k-1];
            assign src_vld = r_vld[k-1];
        end

        assign en[k] = !r_vld[k] || en[k+1];

        always_comb begin
            logic [DW:0] s_in;
            logic [DW:0] s_out;
            n_st = src;
            for (int j = 0; j < SP; j++) begin
                s_in  = sfade_pkg::div_step(n_st.rem_in, i_fade_in);
                s_out = sfade_pkg::div_step(n_st.rem_out, i_fade_out);
                n_st.rem_in  = s_in[DW-1:0];
                n_st.q_in    = {n_st.q_in[QW-2:0], s_in[DW]};
                n_st.rem_out = s_out[DW-1:0];
                n_st.q_out   = {n_st.q_out[QW-2:0], s_out[DW]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfade_mix.sv
// ----------------------------------------------------------------------------
// sfade_mix - gain select and sample scaling
// Picks the smaller window gain, multiplies the sample by it and rounds
// down by 2^16; chroma is scaled about its midpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module sfade_mix (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire sfade_pkg::t_div  i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sfade_pkg::t_res       o_data
);

    localparam int unsigned AW = sfade_pkg::ALPHA_W;
    localparam int unsigned SW = sfade_pkg::SAMPLE_W;
    localparam int unsigned FW = sfade_pkg::FRAC_W;
    localparam int unsigned PW = 2 * (SW + 1);

    // gain select stage
    logic                   r_vld_c;
    logic [AW-1:0]          r_alpha_c;
    logic signed [SW:0]     r_seff_c;
    logic signed [SW-1:0]   r_sample_c;
    logic                   r_chroma_c;
    // multiply stage
    logic                   r_vld_m;
    logic [AW-1:0]          r_alpha_m;
    logic signed [PW-1:0]   r_prod_m;
    logic signed [SW-1:0]   r_sample_m;
    logic                   r_chroma_m;
    // output stage
    logic                   r_vld_o;
    sfade_pkg::t_res        r_res_o;

    logic                   en_c;
    logic                   en_m;
    logic                   en_o;
    logic [AW-1:0]          a_in;
    logic [AW-1:0]          a_out;
    logic [AW-1:0]          n_alpha_c;
    logic signed [SW:0]     n_seff_c;
    logic                   chroma;
    logic signed [PW-1:0]   n_prod_m;
    logic signed [PW-FW-1:0] shifted;
    logic signed [PW-FW-1:0] scaled;
    sfade_pkg::t_res        n_res_o;

    assign en_o    = !r_vld_o || i_ready;
    assign en_m    = !r_vld_m || en_o;
    assign en_c    = !r_vld_c || en_m;
    assign o_ready = en_c;
    assign o_valid = r_vld_o;
    assign o_data  = r_res_o;

    always_comb begin
        chroma = (i_data.op == sfade_pkg::OP_CHROMA);
        if (!i_data.in_act) begin
            a_in = sfade_pkg::ALPHA_ONE;
        end else if (i_data.in_zero) begin
            a_in = '0;
        end else begin
            a_in = {1'b0, i_data.q_in};
        end
        if (!i_data.out_act) begin
            a_out = sfade_pkg::ALPHA_ONE;
        end else if (i_data.out_zero) begin
            a_out = '0;
        end else begin
            a_out = sfade_pkg::ALPHA_ONE - {1'b0, i_data.q_out};
        end
        n_alpha_c = (a_in < a_out) ? a_in : a_out;
        n_seff_c  = chroma ? ((SW + 1)'(i_data.sample) - sfade_pkg::CHROMA_MID)
                           : (SW + 1)'(i_data.sample);
    end

    always_comb begin
        n_prod_m = PW'(r_seff_c) * PW'($signed({1'b0, r_alpha_c[FW-1:0]}));
    end

    always_comb begin
        shifted = r_prod_m[PW-1:FW];
        scaled  = r_chroma_m ? (shifted + (PW - FW)'(sfade_pkg::CHROMA_MID)) : shifted;
        n_res_o.alpha      = r_alpha_m;
        // full gain passes the sample untouched
        n_res_o.sample_out = r_alpha_m[FW] ? r_sample_m : scaled[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_m <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            if (en_c) begin
                r_vld_c <= i_valid;
            end
            if (en_m) begin
                r_vld_m <= r_vld_c;
            end
            if (en_o) begin
                r_vld_o <= r_vld_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_alpha_c  <= n_alpha_c;
            r_seff_c   <= n_seff_c;
            r_sample_c <= i_data.sample;
            r_chroma_c <= chroma;
        end
        if (en_m) begin
            r_alpha_m  <= r_alpha_c;
            r_prod_m   <= n_prod_m;
            r_sample_m <= r_sample_c;
            r_chroma_m <= r_chroma_c;
        end
        if (en_o) begin
            r_res_o <= n_res_o;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/segment_fade_yuv_audio.sv
// ----------------------------------------------------------------------------
// segment_fade_yuv_audio - linear fade to black in Q16 for video and audio
//
// Samples enter on the s_axis stream: tdata carries the sample and its time
// within the segment, tuser the sample kind (luma, chroma, audio). Each
// sample leaves on m_axis with the faded value and the Q16 gain applied.
// The fade-in, fade-out and segment lengths are set over the cfg write
// channel, which is always ready; write them only while no sample is in
// flight.
// An input transaction reaches its output through one decode
// stage, eight divider stages (two quotient bits each, set by the 16-bit
// gain fraction), then gain select, multiply and output stages.
// Throughput is one sample per clock unless m_axis stalls. Every stage has
// its own valid bit and loads when empty or when the stage after it moves,
// so a stall on m_axis fills the bubbles first and only then drops
// s_axis_tready; nothing is lost or repeated. Reset clears the valid
// bits and all three lengths to zero (both fades off, gain 65536).
// ----------------------------------------------------------------------------
`default_nettype none

module segment_fade_yuv_audio (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [sfade_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [sfade_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input samples
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // [15:0] sample_in, [47:16] segment_time_ms
    input  wire logic [1:0]   s_axis_tuser,  // [1:0] op
    // output samples
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [39:0]       m_axis_tdata   // [15:0] sample_out, [32:16] alpha_used, rest 0
);

    localparam int unsigned SW = sfade_pkg::SAMPLE_W;
    localparam int unsigned TW = sfade_pkg::TIME_W;
    localparam int unsigned AW = sfade_pkg::ALPHA_W;

    logic [sfade_pkg::DUR_W-1:0] r_fade_in;
    logic [sfade_pkg::DUR_W-1:0] r_fade_out;
    logic [sfade_pkg::LEN_W-1:0] r_seg_len;

    logic             prep_valid;
    logic             prep_ready;
    sfade_pkg::t_prep prep_data;
    logic             div_valid;
    logic             div_ready;
    sfade_pkg::t_div  div_data;
    sfade_pkg::t_res  res_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in  <= '0;
            r_fade_out <= '0;
            r_seg_len  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfade_pkg::CFG_FADE_IN:  r_fade_in  <= i_cfg_data[sfade_pkg::DUR_W-1:0];
                sfade_pkg::CFG_FADE_OUT: r_fade_out <= i_cfg_data[sfade_pkg::DUR_W-1:0];
                sfade_pkg::CFG_SEG_LEN:  r_seg_len  <= i_cfg_data[sfade_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sfade_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fade_in  (r_fade_in),
        .i_fade_out (r_fade_out),
        .i_seg_len  (r_seg_len),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_sample   ($signed(s_axis_tdata[SW-1:0])),
        .i_time     ($signed(s_axis_tdata[SW+TW-1:SW])),
        .o_valid    (prep_valid),
        .i_ready    (prep_ready),
        .o_data     (prep_data)
    );

    sfade_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fade_in  (r_fade_in),
        .i_fade_out (r_fade_out),
        .i_valid    (prep_valid),
        .o_ready    (prep_ready),
        .i_data     (prep_data),
        .o_valid    (div_valid),
        .i_ready    (div_ready),
        .o_data     (div_data)
    );

    sfade_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_valid),
        .o_ready    (div_ready),
        .i_data     (div_data),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (res_data)
    );

    assign m_axis_tdata = {{(40 - SW - AW){1'b0}}, res_data.alpha, res_data.sample_out};

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for segment_fade_yuv_audio
// Drives luma, chroma and audio samples with segment times across several
// fade-in / fade-out / segment-length settings, predicts the Q16 gain and
// faded sample of every accepted transaction and checks each output in order
// under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned OP_W       = sfade_pkg::OP_W;
    localparam int unsigned SAMPLE_W   = sfade_pkg::SAMPLE_W;
    localparam int unsigned TIME_W     = sfade_pkg::TIME_W;
    localparam int unsigned DUR_W      = sfade_pkg::DUR_W;
    localparam int unsigned LEN_W      = sfade_pkg::LEN_W;
    localparam int unsigned ALPHA_W    = sfade_pkg::ALPHA_W;
    localparam int unsigned CFG_IDX_W  = sfade_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = sfade_pkg::CFG_DATA_W;

    localparam logic [OP_W-1:0] OP_LUMA  = 2'd0;
    localparam logic [OP_W-1:0] OP_AUDIO = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam longint GAIN_ONE      = 65536;
    localparam longint CHROMA_CENTER = 128;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [TIME_W-1:0] T_MIN  = 32'h8000_0000;
    localparam logic [TIME_W-1:0] T_MAX  = 32'h7FFF_FFFF;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 24;
    localparam int RAND_ITEMS  = 85;
    localparam int EXP_DEPTH   = 64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [ALPHA_W-1:0]  gain;
    } t_faded;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;

    // bench copy of the fade and segment length registers
    logic [DUR_W-1:0] fade_in_len;
    logic [DUR_W-1:0] fade_out_len;
    logic [LEN_W-1:0] seg_len;

    // expected results in send order, ring indexed by running counts
    t_faded exp_ring [EXP_DEPTH];
    int     exp_wr;
    int     exp_rd;
    t_faded want;

    int src_idle_pct;
    int sink_idle_pct;
    int error_count;
    int samples_sent;
    int samples_checked;
    int settings_used;
    int stall_cycles;

    segment_fade_yuv_audio dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // gain and sample prediction
    // ------------------------------------------------------------------------
    function automatic logic [ALPHA_W-1:0] fade_gain(input logic signed [TIME_W-1:0] t);
        longint tt;
        longint gain;
        longint g;
        longint start;
        tt   = t;
        gain = GAIN_ONE;
        if (fade_in_len != 0 && tt < longint'(fade_in_len)) begin
            g = (tt * GAIN_ONE) / longint'(fade_in_len);
            if (g < gain) gain = g;
        end
        if (fade_out_len != 0) begin
            start = longint'(seg_len) - longint'(fade_out_len);
            if (tt >= start) begin
                g = GAIN_ONE - ((tt - start) * GAIN_ONE) / longint'(fade_out_len);
                if (g < gain) gain = g;
            end
        end
        if (gain < 0) gain = 0;
        return gain[ALPHA_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] faded_sample(input logic [OP_W-1:0] op,
                                                         input logic signed [SAMPLE_W-1:0] s,
                                                         input logic [ALPHA_W-1:0] gain);
        longint ss;
        longint gg;
        longint r;
        ss = s;
        gg = longint'(gain);
        if (gg >= GAIN_ONE) begin
            r = ss;
        end else if (op == sfade_pkg::OP_CHROMA) begin
            r = CHROMA_CENTER + (((ss - CHROMA_CENTER) * gg) >>> 16);
        end else begin
            r = (ss * gg) >>> 16;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // stream and register drivers
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s,
                               input logic [TIME_W-1:0] t);
        t_faded f;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, s};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        f.gain   = fade_gain(t);
        f.sample = faded_sample(op, s, f.gain);
        exp_ring[exp_wr % EXP_DEPTH] = f;
        exp_wr++;
        samples_sent++;
    endtask

    // drop valid and let every outstanding sample come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            sfade_pkg::CFG_FADE_IN:  fade_in_len  = d[DUR_W-1:0];
            sfade_pkg::CFG_FADE_OUT: fade_out_len = d[DUR_W-1:0];
            sfade_pkg::CFG_SEG_LEN:  seg_len      = d[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_fade(input logic [DUR_W-1:0] fin, input logic [DUR_W-1:0] fout,
                            input logic [LEN_W-1:0] len);
        wait_drain();
        write_reg(sfade_pkg::CFG_FADE_IN, CFG_DATA_W'(fin));
        write_reg(sfade_pkg::CFG_FADE_OUT, CFG_DATA_W'(fout));
        write_reg(sfade_pkg::CFG_SEG_LEN, CFG_DATA_W'(len));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // output checker, sink stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected output transaction tdata=%h", m_axis_tdata);
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                samples_checked++;
                if (m_axis_tdata[15:0] !== want.sample || m_axis_tdata[32:16] !== want.gain) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: result %0d sample exp %h got %h, gain exp %0d got %0d",
                                 samples_checked, want.sample, m_axis_tdata[15:0],
                                 want.gain, m_axis_tdata[32:16]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------------
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DUR_W'($urandom_range(1, 64));
            2:       return DUR_W'($urandom_range(65, 5000));
            default: return DUR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        longint lo;
        int unsigned span;
        case ($urandom_range(0, 5))
            0, 1: begin
                lo   = -64;
                span = int'(fade_in_len) + 128;
            end
            2, 3: begin
                lo   = longint'(seg_len) - longint'(fade_out_len) - 64;
                span = int'(fade_out_len) + 128;
            end
            4: begin
                lo   = -64;
                span = int'(seg_len) + 128;
            end
            default: begin
                return $urandom;
            end
        endcase
        lo = lo + longint'($urandom_range(0, span));
        return lo[TIME_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_pass_through();
        // reset state: both fades off, every sample passes at full gain
        send_sample(OP_LUMA, 16'd0, T_MIN);
        send_sample(OP_LUMA, 16'd255, T_MAX);
        send_sample(sfade_pkg::OP_CHROMA, 16'd0, 32'd0);
        send_sample(sfade_pkg::OP_CHROMA, 16'd255, 32'hFFFF_FFFF);
        send_sample(OP_AUDIO, 16'h8000, 32'd17);
        send_sample(OP_SPARE, 16'h7FFF, 32'h5555_AAAA);
    endtask

    task automatic test_fade_in();
        set_fade(20'd1000, '0, 31'd5000);
        send_sample(OP_LUMA, 16'd200, 32'd0);
        send_sample(OP_LUMA, 16'd200, 32'd500);
        send_sample(sfade_pkg::OP_CHROMA, 16'd10, 32'd500);
        send_sample(OP_AUDIO, 16'h8000, 32'd999);
        // negative time gives a negative gain, clamp to zero
        send_sample(sfade_pkg::OP_CHROMA, 16'd240, 32'hFFFF_FFFF);
        send_sample(OP_AUDIO, 16'h7FFF, 32'd1000);
        // luma and chroma out of the 8-bit range keep the same formula
        send_sample(OP_LUMA, 16'hFFFB, 32'd250);
        send_sample(sfade_pkg::OP_CHROMA, 16'd1000, 32'd250);
    endtask

    task automatic test_fade_out();
        set_fade('0, 20'd400, 31'd1000);
        send_sample(OP_LUMA, 16'd255, 32'd600);
        send_sample(sfade_pkg::OP_CHROMA, 16'd0, 32'd800);
        send_sample(OP_AUDIO, 16'h7FFF, 32'd999);
        send_sample(OP_SPARE, 16'h8001, 32'd1000);
        // past the segment end the gain overflows below zero
        send_sample(sfade_pkg::OP_CHROMA, 16'd77, 32'd5000);
        send_sample(OP_LUMA, 16'd128, T_MAX);
    endtask

    task automatic test_length_extremes();
        set_fade(DUR_MAX, DUR_MAX, LEN_MAX);
        send_sample(OP_AUDIO, 16'h8000, T_MIN);
        send_sample(sfade_pkg::OP_CHROMA, 16'd255, T_MAX);
        send_sample(OP_LUMA, 16'd255, 32'h7FF0_0000);
        // fade-out longer than the segment: both windows overlap at zero
        set_fade(DUR_MAX, DUR_MAX, '0);
        send_sample(OP_AUDIO, 16'h7FFF, 32'd0);
        send_sample(sfade_pkg::OP_CHROMA, 16'd3, 32'h000F_FFFE);
    endtask

    task automatic test_random_fades(input int src_pct, input int sink_pct);
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] s;
        logic [DUR_W-1:0]    fin;
        logic [DUR_W-1:0]    fout;
        logic [LEN_W-1:0]    len;
        int                  k;
        int                  n;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (k = 0; k < 4; k++) begin
            fin  = pick_duration();
            fout = pick_duration();
            case ($urandom_range(0, 2))
                0:       len = LEN_W'($urandom_range(0, 20000));
                1:       len = LEN_W'($urandom);
                default: len = LEN_W'(fin) + LEN_W'(fout) + LEN_W'($urandom_range(0, 1000));
            endcase
            if (k == 0) begin
                fin  = DUR_W'($urandom_range(1, 300));
                fout = DUR_W'($urandom_range(1, 300));
                len  = LEN_W'($urandom_range(0, 100));
            end
            set_fade(fin, fout, len);
            for (n = 0; n < RAND_ITEMS; n++) begin
                op = ($urandom_range(0, 15) == 15) ? OP_SPARE : OP_W'($urandom_range(0, 2));
                if ((op == OP_LUMA || op == sfade_pkg::OP_CHROMA) &&
                    $urandom_range(0, 4) != 0)
                    s = SAMPLE_W'($urandom_range(0, 255));
                else
                    s = SAMPLE_W'($urandom);
                send_sample(op, s, pick_time());
            end
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        fade_in_len   = '0;
        fade_out_len  = '0;
        seg_len       = '0;
        exp_wr        = 0;
        exp_rd        = 0;
        src_idle_pct  = 27;
        sink_idle_pct = 46;
        error_count     = 0;
        samples_sent    = 0;
        samples_checked = 0;
        settings_used   = 1;
        stall_cycles    = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pass_through();
        test_fade_in();
        test_fade_out();
        test_length_extremes();
        test_random_fades(27, 46);
        test_random_fades(46, 27);
        test_random_fades(0, 0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Faded %0d samples (luma, chroma, audio, spare kind) over %0d gain settings;",
                 samples_sent, settings_used);
        $display("%0d outputs compared under source gaps and sink stalls, %0d mismatches.",
                 samples_checked, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sfade_pkg.sv
rtl/sfade_prep.sv
rtl/sfade_div.sv
rtl/sfade_mix.sv
rtl/segment_fade_yuv_audio.sv
tb/sv/tb.sv
